// File: design/bat_pkg.sv
package bat_pkg;

    // Default geometry of the thumbnail and the largest accepted source.
    localparam int OUT_SIZE_DEF = 64;
    localparam int MAX_DIM_DEF  = 1024;

    // Fixed field widths.
    localparam int SIZE_W    = 11;
    localparam int CHAN_W    = 8;
    localparam int COORD_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(CHAN_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

    // Reset value of both size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    // Per-pixel flags from the band tracker.
    typedef struct packed {
        logic emit;
        logic image_done;
    } band_tag_t;

    // Divider sequencer states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

// File: design/bat_band.sv
module bat_band #(
    parameter int OUT_SIZE = bat_pkg::OUT_SIZE_DEF,
    parameter int MAX_DIM  = bat_pkg::MAX_DIM_DEF,
    localparam int IDX_W   = $clog2(OUT_SIZE),
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int PROD_W  = $clog2((MAX_DIM + 1) * OUT_SIZE + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [bat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bat_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          advance,
    output logic                          restart,
    output logic [IDX_W-1:0]              col_band,
    output logic [IDX_W-1:0]              row_band,
    output bat_pkg::band_tag_t            tag
);

    localparam logic [PROD_W-1:0] N_P      = PROD_W'(OUT_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(OUT_SIZE - 1);

    // Clamp a size register into the supported range.
    function automatic logic [DIM_W-1:0] eff_size(input logic [bat_pkg::SIZE_W-1:0] v);
        if (32'(v) < 32'(OUT_SIZE)) begin
            return DIM_W'(OUT_SIZE);
        end
        else if (32'(v) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [bat_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [bat_pkg::SIZE_W-1:0] width_next, height_next;
    logic [DIM_W-1:0]           col_reg, row_reg;
    logic [IDX_W-1:0]           cb_reg, rb_reg;
    // coln = (col+1)*N, cbw = (cb+1)*W, and likewise for rows.
    logic [PROD_W-1:0]          coln_reg, cbw_reg, rown_reg, rbh_reg;

    logic [DIM_W-1:0]  w_eff, h_eff, w_eff_next, h_eff_next;
    logic [PROD_W-1:0] coln_inc, rown_inc;
    logic              col_hit, row_hit, line_end, frame_end;
    logic [DIM_W:0]    col_plus, row_plus;
    logic              wr_w, wr_h;

    // Register write decode.
    always_comb
    begin
        wr_w = 1'b0;
        wr_h = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                bat_pkg::REG_SOURCE_WIDTH:  wr_w = 1'b1;
                bat_pkg::REG_SOURCE_HEIGHT: wr_h = 1'b1;
                default: ;
            endcase
        end
    end

    assign restart     = wr_w | wr_h;
    assign width_next  = wr_w ? cfg_data : width_reg;
    assign height_next = wr_h ? cfg_data : height_reg;
    assign w_eff       = eff_size(width_reg);
    assign h_eff       = eff_size(height_reg);
    assign w_eff_next  = eff_size(width_next);
    assign h_eff_next  = eff_size(height_next);

    // Band boundary tests, done as cross products instead of divisions.
    // col+1 >= floor((cb+1)*W/N) holds exactly when (col+2)*N > (cb+1)*W.
    assign coln_inc  = coln_reg + N_P;
    assign rown_inc  = rown_reg + N_P;
    assign col_hit   = coln_inc > cbw_reg;
    assign row_hit   = rown_inc > rbh_reg;
    assign col_plus  = {1'b0, col_reg} + (DIM_W+1)'(1);
    assign row_plus  = {1'b0, row_reg} + (DIM_W+1)'(1);
    assign line_end  = col_plus >= {1'b0, w_eff};
    assign frame_end = row_plus >= {1'b0, h_eff};

    assign col_band       = cb_reg;
    assign row_band       = rb_reg;
    assign tag.emit       = col_hit && row_hit;
    assign tag.image_done = col_hit && row_hit && (cb_reg == LAST_IDX) && (rb_reg == LAST_IDX);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= bat_pkg::SIZE_RESET;
            height_reg <= bat_pkg::SIZE_RESET;
        end
        else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Raster position and band tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg  <= '0;
            row_reg  <= '0;
            cb_reg   <= '0;
            rb_reg   <= '0;
            coln_reg <= N_P;
            rown_reg <= N_P;
            cbw_reg  <= PROD_W'(eff_size(bat_pkg::SIZE_RESET));
            rbh_reg  <= PROD_W'(eff_size(bat_pkg::SIZE_RESET));
        end
        else if (restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            cb_reg   <= '0;
            rb_reg   <= '0;
            coln_reg <= N_P;
            rown_reg <= N_P;
            cbw_reg  <= PROD_W'(w_eff_next);
            rbh_reg  <= PROD_W'(h_eff_next);
        end
        else if (advance) begin
            if (line_end) begin
                col_reg  <= '0;
                coln_reg <= N_P;
                cb_reg   <= '0;
                cbw_reg  <= PROD_W'(w_eff);
                if (frame_end) begin
                    row_reg  <= '0;
                    rown_reg <= N_P;
                    rb_reg   <= '0;
                    rbh_reg  <= PROD_W'(h_eff);
                end
                else begin
                    row_reg  <= DIM_W'(row_plus);
                    rown_reg <= rown_inc;
                    if (row_hit && rb_reg != LAST_IDX) begin
                        rb_reg  <= rb_reg + IDX_W'(1);
                        rbh_reg <= rbh_reg + PROD_W'(h_eff);
                    end
                end
            end
            else begin
                col_reg  <= DIM_W'(col_plus);
                coln_reg <= coln_inc;
                if (col_hit && cb_reg != LAST_IDX) begin
                    cb_reg  <= cb_reg + IDX_W'(1);
                    cbw_reg <= cbw_reg + PROD_W'(w_eff);
                end
            end
        end
    end

endmodule

// File: design/bat_accum.sv
module bat_accum #(
    parameter int OUT_SIZE = bat_pkg::OUT_SIZE_DEF,
    parameter int CNT_W    = 9,
    localparam int IDX_W   = $clog2(OUT_SIZE),
    localparam int SUM_W   = CNT_W + bat_pkg::CHAN_W,
    localparam int WORD_W  = 4 * SUM_W + CNT_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             restart,
    input  logic                             pix_valid,
    input  logic [IDX_W-1:0]                 col_band,
    input  logic [IDX_W-1:0]                 row_band,
    input  bat_pkg::band_tag_t               tag,
    input  logic [bat_pkg::CHAN_W-1:0]       red,
    input  logic [bat_pkg::CHAN_W-1:0]       green,
    input  logic [bat_pkg::CHAN_W-1:0]       blue,
    input  logic [bat_pkg::CHAN_W-1:0]       alpha,
    output logic                             job_valid,
    output logic [3:0][SUM_W-1:0]            job_sum,
    output logic [CNT_W-1:0]                 job_count,
    output logic [bat_pkg::COORD_W-1:0]      job_x,
    output logic [bat_pkg::COORD_W-1:0]      job_y,
    output logic                             job_done
);

    // Accumulator store: four channel sums and a sample count per column band.
    logic [WORD_W-1:0]   mem [OUT_SIZE];
    logic [OUT_SIZE-1:0] vld_reg;

    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_vld_reg;

    // Read-modify-write stage.
    logic                                 s1_valid_reg;
    logic [IDX_W-1:0]                     s1_addr_reg;
    logic [IDX_W-1:0]                     s1_row_reg;
    bat_pkg::band_tag_t                   s1_tag_reg;
    logic [3:0][bat_pkg::CHAN_W-1:0]      s1_pix_reg;

    // Last write, forwarded to a read issued in the same cycle.
    logic                byp_valid_reg;
    logic [IDX_W-1:0]    byp_addr_reg;
    logic [WORD_W-1:0]   byp_data_reg;

    logic [WORD_W-1:0]   cur_word, new_word, wr_word;
    logic [3:0][SUM_W-1:0] new_sum;
    logic [CNT_W-1:0]    new_count;

    // Pick the current entry: forwarded write, stored value, or cleared.
    always_comb
    begin
        if (byp_valid_reg && byp_addr_reg == s1_addr_reg) begin
            cur_word = byp_data_reg;
        end
        else if (rd_vld_reg) begin
            cur_word = rd_data_reg;
        end
        else begin
            cur_word = '0;
        end
    end

    // Add the pixel to its column band.
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            new_sum[i] = cur_word[CNT_W + i*SUM_W +: SUM_W] + SUM_W'(s1_pix_reg[i]);
        end
        new_count = cur_word[CNT_W-1:0] + CNT_W'(1);
        new_word  = {new_sum[3], new_sum[2], new_sum[1], new_sum[0], new_count};
        wr_word   = s1_tag_reg.emit ? '0 : new_word;
    end

    assign job_valid = s1_valid_reg && s1_tag_reg.emit;
    assign job_sum   = new_sum;
    assign job_count = new_count;
    assign job_x     = bat_pkg::COORD_W'(s1_addr_reg);
    assign job_y     = bat_pkg::COORD_W'(s1_row_reg);
    assign job_done  = s1_tag_reg.image_done;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= wr_word;
        end
        if (pix_valid) begin
            rd_data_reg <= mem[col_band];
        end
    end

    // Entry valid bits; a restart clears every entry at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (restart) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else begin
            if (s1_valid_reg) begin
                vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (pix_valid) begin
                rd_vld_reg <= vld_reg[col_band];
            end
        end
    end

    // Stage control and forwarding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else if (restart) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= pix_valid;
            byp_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (pix_valid) begin
            s1_addr_reg   <= col_band;
            s1_row_reg    <= row_band;
            s1_tag_reg    <= tag;
            s1_pix_reg[0] <= red;
            s1_pix_reg[1] <= green;
            s1_pix_reg[2] <= blue;
            s1_pix_reg[3] <= alpha;
        end
        if (s1_valid_reg) begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= wr_word;
        end
    end

endmodule

// File: design/bat_div.sv
module bat_div #(
    parameter int CNT_W  = 9,
    localparam int SUM_W = CNT_W + bat_pkg::CHAN_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_valid,
    input  logic [3:0][SUM_W-1:0]            job_sum,
    input  logic [CNT_W-1:0]                 job_count,
    input  logic [bat_pkg::COORD_W-1:0]      job_x,
    input  logic [bat_pkg::COORD_W-1:0]      job_y,
    input  logic                             job_done,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [3:0][bat_pkg::CHAN_W-1:0]  quot,
    output logic [bat_pkg::COORD_W-1:0]      out_x,
    output logic [bat_pkg::COORD_W-1:0]      out_y,
    output logic                             image_done
);

    localparam logic [bat_pkg::STEP_W-1:0] STEP_FIRST = bat_pkg::STEP_W'(bat_pkg::CHAN_W - 1);

    bat_pkg::div_state_t state_reg, state_next;

    logic [bat_pkg::STEP_W-1:0]         step_reg;
    logic [CNT_W-1:0]                   divisor_reg;
    logic [3:0][SUM_W-1:0]              rem_reg;
    logic [3:0][bat_pkg::CHAN_W-1:0]    quot_reg;
    logic [bat_pkg::COORD_W-1:0]        x_reg, y_reg;
    logic                               done_reg;

    logic [SUM_W-1:0]                   shifted;
    logic [3:0]                         fits;
    logic                               run_step, last_step;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bat_pkg::DIV_IDLE: if (job_valid) state_next = bat_pkg::DIV_RUN;
            bat_pkg::DIV_RUN:  if (last_step) state_next = bat_pkg::DIV_HOLD;
            bat_pkg::DIV_HOLD: if (out_ready) state_next = bat_pkg::DIV_IDLE;
            default:           state_next = bat_pkg::DIV_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy      = 1'b1;
        out_valid = 1'b0;
        run_step  = 1'b0;
        unique case (state_reg)
            bat_pkg::DIV_IDLE: busy      = 1'b0;
            bat_pkg::DIV_RUN:  run_step  = 1'b1;
            bat_pkg::DIV_HOLD: out_valid = 1'b1;
            default:           busy      = 1'b0;
        endcase
    end

    assign last_step = run_step && (step_reg == '0);

    // One quotient bit per lane each cycle, most significant first.
    always_comb
    begin
        shifted = SUM_W'(divisor_reg) << step_reg;
        for (int i = 0; i < 4; i++) begin
            fits[i] = rem_reg[i] >= shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= bat_pkg::DIV_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Division datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == bat_pkg::DIV_IDLE && job_valid) begin
            step_reg    <= STEP_FIRST;
            divisor_reg <= job_count;
            rem_reg     <= job_sum;
            quot_reg    <= '0;
            x_reg       <= job_x;
            y_reg       <= job_y;
            done_reg    <= job_done;
        end
        else if (run_step) begin
            step_reg <= step_reg - bat_pkg::STEP_W'(1);
            for (int i = 0; i < 4; i++) begin
                quot_reg[i] <= {quot_reg[i][bat_pkg::CHAN_W-2:0], fits[i]};
                if (fits[i]) begin
                    rem_reg[i] <= rem_reg[i] - shifted;
                end
            end
        end
    end

    assign quot       = quot_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign image_done = done_reg;

endmodule

// File: design/box_average_thumbnail_downscaler.sv
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       in_valid / in_ready    red, green, blue, alpha (one source pixel)
// out      out_valid / out_ready  avg_red, avg_green, avg_blue, avg_alpha,
//                                 out_x, out_y, image_done
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (size registers)
//
// A pixel is read from the accumulator memory in its accept cycle and written back in the next
// cycle, with forwarding, so pixels stream at one per cycle unless a band-closing pixel stalls.
// A pixel that closes a band starts a divider job; while the divider is busy or its result
// waits on out_ready, the next band-closing pixel stalls.
// Reset and any size write clear every accumulator at once through per-entry valid bits.
module box_average_thumbnail_downscaler #(
    parameter int OUT_SIZE = bat_pkg::OUT_SIZE_DEF,
    parameter int MAX_DIM  = bat_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bat_pkg::CHAN_W-1:0]    red,
    input  logic [bat_pkg::CHAN_W-1:0]    green,
    input  logic [bat_pkg::CHAN_W-1:0]    blue,
    input  logic [bat_pkg::CHAN_W-1:0]    alpha,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bat_pkg::CHAN_W-1:0]    avg_red,
    output logic [bat_pkg::CHAN_W-1:0]    avg_green,
    output logic [bat_pkg::CHAN_W-1:0]    avg_blue,
    output logic [bat_pkg::CHAN_W-1:0]    avg_alpha,
    output logic [bat_pkg::COORD_W-1:0]   out_x,
    output logic [bat_pkg::COORD_W-1:0]   out_y,
    output logic                          image_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bat_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int IDX_W    = $clog2(OUT_SIZE);
    localparam int BAND_MAX = (MAX_DIM + OUT_SIZE - 1) / OUT_SIZE;
    localparam int CNT_W    = $clog2(BAND_MAX * BAND_MAX + 1);
    localparam int SUM_W    = CNT_W + bat_pkg::CHAN_W;

    logic                                 restart;
    logic                                 pix_xfer;
    logic [IDX_W-1:0]                     col_band, row_band;
    bat_pkg::band_tag_t                   band_tag;
    logic                                 job_valid, job_done, div_busy;
    logic [3:0][SUM_W-1:0]                job_sum;
    logic [CNT_W-1:0]                     job_count;
    logic [bat_pkg::COORD_W-1:0]          job_x, job_y;
    logic [3:0][bat_pkg::CHAN_W-1:0]      quot;

    // Size registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    // Hold a band-closing pixel until the divider can take its job.
    assign in_ready = !(band_tag.emit && (job_valid || div_busy));
    assign pix_xfer = in_valid && in_ready;

    bat_band #(
        .OUT_SIZE (OUT_SIZE),
        .MAX_DIM  (MAX_DIM)
    ) u_band (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (pix_xfer),
        .restart   (restart),
        .col_band  (col_band),
        .row_band  (row_band),
        .tag       (band_tag)
    );

    bat_accum #(
        .OUT_SIZE (OUT_SIZE),
        .CNT_W    (CNT_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .pix_valid (pix_xfer),
        .col_band  (col_band),
        .row_band  (row_band),
        .tag       (band_tag),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .job_valid (job_valid),
        .job_sum   (job_sum),
        .job_count (job_count),
        .job_x     (job_x),
        .job_y     (job_y),
        .job_done  (job_done)
    );

    bat_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_sum    (job_sum),
        .job_count  (job_count),
        .job_x      (job_x),
        .job_y      (job_y),
        .job_done   (job_done),
        .busy       (div_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .quot       (quot),
        .out_x      (out_x),
        .out_y      (out_y),
        .image_done (image_done)
    );

    assign avg_red   = quot[0];
    assign avg_green = quot[1];
    assign avg_blue  = quot[2];
    assign avg_alpha = quot[3];

`ifndef NO_ASSERTIONS
    // The divider never receives a job while it still holds one.
    assert property (@(posedge clk) disable iff (!rst_n) job_valid |-> !div_busy)
        else $error("divider job issued while busy");

    // A transferred band-closing pixel produces a divider job in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_xfer && band_tag.emit && !restart) |=> job_valid)
        else $error("band-closing pixel lost its divider job");

    // The last result of an image sits at the bottom-right thumbnail corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_done) |->
            (out_x == bat_pkg::COORD_W'(OUT_SIZE - 1)) &&
            (out_y == bat_pkg::COORD_W'(OUT_SIZE - 1)))
        else $error("image_done away from the final thumbnail pixel");
`endif

endmodule

// File: tb/sv/tb_box_average_thumbnail_downscaler.sv
module tb_box_average_thumbnail_downscaler;
    import bat_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 12;
    localparam int RESET_CYCLES    = 7;

    // Indexes past the two size registers; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               done;
    } thumb_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    value;
        pixel_t               pixel;
        logic                 typed;
        thumb_t               result;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CHAN_W-1:0]    red = '0;
    logic [CHAN_W-1:0]    green = '0;
    logic [CHAN_W-1:0]    blue = '0;
    logic [CHAN_W-1:0]    alpha = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAN_W-1:0]    avg_red;
    logic [CHAN_W-1:0]    avg_green;
    logic [CHAN_W-1:0]    avg_blue;
    logic [CHAN_W-1:0]    avg_alpha;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic                 image_done;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    box_average_thumbnail_downscaler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .avg_red    (avg_red),
        .avg_green  (avg_green),
        .avg_blue   (avg_blue),
        .avg_alpha  (avg_alpha),
        .out_x      (out_x),
        .out_y      (out_y),
        .image_done (image_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Thumbnail pixels predicted but not yet seen on the output.
    thumb_t pending_thumbs[$];

    // Shared knobs and tallies.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned ready_hold_off = 0;
    int unsigned pixels_sent = 0;
    int unsigned thumbs_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned images_closed = 0;
    int unsigned errors = 0;

    // Predictor state: size registers, per-column accumulators and stream position.
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    int unsigned acc_red[OUT_SIZE_DEF];
    int unsigned acc_green[OUT_SIZE_DEF];
    int unsigned acc_blue[OUT_SIZE_DEF];
    int unsigned acc_alpha[OUT_SIZE_DEF];
    int unsigned acc_samples[OUT_SIZE_DEF];
    int unsigned pos_x;
    int unsigned pos_y;
    int unsigned band_x;
    int unsigned band_y;
    int unsigned band_x_limit;
    int unsigned band_y_limit;

    // A size register value is clamped into the supported range.
    function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
        int unsigned dim;
        dim = 32'(v);
        if (dim < OUT_SIZE_DEF)
            return OUT_SIZE_DEF;
        if (dim > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return dim;
    endfunction

    // Exclusive end of a band along a dimension.
    function automatic int unsigned band_limit(input int unsigned band, input int unsigned dim);
        return ((band + 1) * dim) / OUT_SIZE_DEF;
    endfunction

    // Clear the accumulators and rewind to the first pixel of an image.
    function automatic void restart_thumb();
        for (int i = 0; i < OUT_SIZE_DEF; i++)
        begin
            acc_red[i] = 0;
            acc_green[i] = 0;
            acc_blue[i] = 0;
            acc_alpha[i] = 0;
            acc_samples[i] = 0;
        end
        pos_x = 0;
        pos_y = 0;
        band_x = 0;
        band_y = 0;
        band_x_limit = band_limit(0, clamp_dim(width_reg));
        band_y_limit = band_limit(0, clamp_dim(height_reg));
    endfunction

    // Only the two size registers exist; any write to one restarts the stream.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [SIZE_W-1:0] value);
        if (idx == REG_SOURCE_WIDTH)
            width_reg = value;
        else if (idx == REG_SOURCE_HEIGHT)
            height_reg = value;
        else
            return;
        restart_thumb();
    endfunction

    // Accumulate one source pixel; returns 1 when it closes a thumbnail pixel.
    function automatic bit average_thumb_pixel(input pixel_t px, output thumb_t res);
        int unsigned w;
        int unsigned h;
        int unsigned b;
        int unsigned n;
        bit          closed;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        b = band_x;
        closed = 1'b0;
        res = '0;
        acc_red[b] += 32'(px.red);
        acc_green[b] += 32'(px.green);
        acc_blue[b] += 32'(px.blue);
        acc_alpha[b] += 32'(px.alpha);
        acc_samples[b] += 1;
        pos_x += 1;
        // Leaving a column band: on the band's last row the mean goes out.
        if (pos_x >= band_x_limit)
        begin
            if (pos_y + 1 >= band_y_limit)
            begin
                n = acc_samples[b];
                res.red = CHAN_W'(acc_red[b] / n);
                res.green = CHAN_W'(acc_green[b] / n);
                res.blue = CHAN_W'(acc_blue[b] / n);
                res.alpha = CHAN_W'(acc_alpha[b] / n);
                res.x = COORD_W'(b);
                res.y = COORD_W'(band_y);
                res.done = (b == OUT_SIZE_DEF - 1) && (band_y == OUT_SIZE_DEF - 1);
                acc_red[b] = 0;
                acc_green[b] = 0;
                acc_blue[b] = 0;
                acc_alpha[b] = 0;
                acc_samples[b] = 0;
                closed = 1'b1;
            end
            if (b + 1 < OUT_SIZE_DEF)
            begin
                band_x = b + 1;
                band_x_limit = band_limit(band_x, w);
            end
        end
        // End of a source row, and wrap to the next image after the last row.
        if (pos_x >= w)
        begin
            pos_x = 0;
            band_x = 0;
            band_x_limit = band_limit(0, w);
            pos_y += 1;
            if (pos_y >= h)
            begin
                pos_y = 0;
                band_y = 0;
                band_y_limit = band_limit(0, h);
            end
            else if (pos_y >= band_y_limit && band_y + 1 < OUT_SIZE_DEF)
            begin
                band_y += 1;
                band_y_limit = band_limit(band_y, h);
            end
        end
        return closed;
    endfunction

    // Directed row for a pixel; a typed row expects the pixel back at column col, row 0.
    function automatic stim_row_t pix_row(input pixel_t px, input bit typed, input int col);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.pixel = px;
        row.typed = typed;
        row.result = {px, COORD_W'(col), COORD_W'(0), 1'b0};
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [SIZE_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.index = idx;
        row.value = value;
        return row;
    endfunction

    // Random channel value with the extremes favored.
    function automatic logic [CHAN_W-1:0] rand_channel();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return CHAN_W'($urandom);
    endfunction

    // Random source size, mostly small so that results come often.
    function automatic logic [SIZE_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return SIZE_W'($urandom_range(64, 140));
        if (roll < 65)
            return SIZE_W'($urandom_range(0, 63));
        if (roll < 80)
            return SIZE_W'($urandom_range(141, 1024));
        if (roll < 90)
            return SIZE_W'($urandom_range(1025, 2047));
        return (roll < 95) ? SIZE_W'(MAX_DIM_DEF) : SIZE_W'(OUT_SIZE_DEF);
    endfunction

    // Offer one pixel, with a random gap first, and predict it once transferred.
    task automatic send_pixel(input pixel_t px, input bit typed, input thumb_t typed_result);
        thumb_t res;
        bit     closed;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {red, green, blue, alpha} <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
        closed = average_thumb_pixel(px, res);
        if (typed)
            pending_thumbs.push_back(typed_result);
        else if (closed)
            pending_thumbs.push_back(res);
    endtask

    // Stop offering pixels until every predicted result is out and the block is quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_thumbs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        apply_reg_write(idx, value);
    endtask

    // Output side: check each transfer against the oldest prediction, then pick ready.
    initial
    begin
        thumb_t got;
        thumb_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {avg_red, avg_green, avg_blue, avg_alpha, out_x, out_y, image_done};
                if (got.done)
                    images_closed++;
                if (pending_thumbs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d x=%0d y=%0d done=%0b",
                             $time, got.red, got.green, got.blue, got.alpha,
                             got.x, got.y, got.done);
                end
                else
                begin
                    want = pending_thumbs.pop_front();
                    thumbs_checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.x !== want.x || got.y !== want.y || got.done !== want.done)
                    begin
                        errors++;
                        $display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d x=%0d y=%0d d=%0b",
                                 $time, want.red, want.green, want.blue, want.alpha,
                                 want.x, want.y, want.done);
                        $display("%0t:          actual   r=%0d g=%0d b=%0d a=%0d x=%0d y=%0d d=%0b",
                                 $time, got.red, got.green, got.blue, got.alpha,
                                 got.x, got.y, got.done);
                    end
                end
            end
            if (ready_hold_off != 0)
            begin
                out_ready <= 1'b0;
                ready_hold_off--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Stimulus.
    initial
    begin
        stim_row_t   directed_rows[$];
        stim_row_t   row;
        pixel_t      px;
        int unsigned mode;
        int unsigned count;

        width_reg = SIZE_RESET;
        height_reg = SIZE_RESET;
        restart_thumb();

        // After reset every band is one pixel, so each pixel comes straight back.
        directed_rows = '{
            pix_row('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 0),
            pix_row('{8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 1),
            pix_row('{8'h55, 8'haa, 8'h0f, 8'hf0}, 1'b1, 2),
            pix_row('{8'haa, 8'h55, 8'hf0, 8'h0f}, 1'b1, 3),
            reg_row(REG_SPARE_LO, 11'h7ff),
            pix_row('{8'h01, 8'h02, 8'h04, 8'h08}, 1'b1, 4),
            reg_row(REG_SPARE_HI, 11'h000),
            pix_row('{8'h80, 8'h40, 8'h20, 8'h10}, 1'b1, 5),
            reg_row(REG_SOURCE_WIDTH, 11'd0),
            pix_row('{8'h10, 8'h20, 8'h30, 8'h40}, 1'b1, 0),
            reg_row(REG_SOURCE_WIDTH, 11'd2047),
            reg_row(REG_SOURCE_HEIGHT, 11'd63),
            pix_row('{8'hff, 8'h00, 8'hff, 8'h00}, 1'b0, 0),
            pix_row('{8'h00, 8'hff, 8'h00, 8'hff}, 1'b0, 0),
            reg_row(REG_SOURCE_WIDTH, 11'd65),
            reg_row(REG_SOURCE_HEIGHT, 11'd1024),
            pix_row('{8'h12, 8'h34, 8'h56, 8'h78}, 1'b0, 0),
            pix_row('{8'h9a, 8'hbc, 8'hde, 8'hf0}, 1'b0, 0),
            reg_row(REG_SOURCE_HEIGHT, 11'd1025),
            pix_row('{8'hfe, 8'h01, 8'h7f, 8'h80}, 1'b0, 0),
            reg_row(REG_SOURCE_WIDTH, 11'd64),
            reg_row(REG_SOURCE_HEIGHT, 11'd64),
            pix_row('{8'h7f, 8'h80, 8'hfe, 8'h01}, 1'b1, 0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.index, row.value);
            else
                send_pixel(row.pixel, row.typed, row.result);
        end

        // Random phases, cycling through the idle and stall mixes.
        for (int phase = 0; phase <= RANDOM_PHASES; phase++)
        begin
            mode = phase % 4;
            case (mode)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase

            if (phase == 0)
            begin
                // Small image and a long receiver hold-off so the block backs up.
                write_reg(REG_SOURCE_WIDTH, SIZE_W'(OUT_SIZE_DEF));
                write_reg(REG_SOURCE_HEIGHT, SIZE_W'($urandom_range(64, 72)));
                ready_hold_off = HOLD_OFF_CYCLES;
                count = 200;
            end
            else
            begin
                case ($urandom_range(3))
                    0: write_reg(REG_SOURCE_WIDTH, pick_dim());
                    1: write_reg(REG_SOURCE_HEIGHT, pick_dim());
                    2:
                    begin
                        write_reg(REG_SOURCE_WIDTH, pick_dim());
                        write_reg(REG_SOURCE_HEIGHT, pick_dim());
                    end
                    default:
                        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                  SIZE_W'($urandom));
                endcase
                count = $urandom_range(60, 190);
            end

            for (int k = 0; k < count; k++)
            begin
                px = '{rand_channel(), rand_channel(), rand_channel(), rand_channel()};
                send_pixel(px, 1'b0, '0);
                // Now and then the source pauses until the block has emptied.
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
        end

        wait_drained();

        $display("Run covered %0d source pixels and %0d register writes, with idle and stall mixes.",
                 pixels_sent, reg_writes);
        $display("Checked %0d thumbnail pixels, %0d full thumbnails closed, %0d errors.",
                 thumbs_checked, images_closed, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
